### src/cdq_pkg.sv
package cdq_pkg;

  // Ring geometry: each ring keeps one slot open, so it holds QUEUE_DEPTH-1 frames
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [3:0] MAX_LEN = 4'd8;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    STAT_PRIMARY = 3'd0,
    STAT_SPILL   = 3'd1,
    STAT_DROPPED = 3'd2,
    STAT_FRAME   = 3'd3,
    STAT_EMPTY   = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } fsm_t;

  // One stored frame, 100 bits
  typedef struct packed {
    logic [7:0]  ident_high;
    logic [7:0]  ident_low;
    logic [7:0]  ext_ident_high;
    logic [7:0]  ext_ident_low;
    logic [3:0]  length;
    logic [31:0] payload_high;
    logic [31:0] payload_low;
  } frame_t;

  localparam int FRAME_W = $bits(frame_t);

  // Pointer updates requested of one ring
  typedef struct packed {
    logic push;
    logic pop;
  } ring_cmd_t;

  // Pointer state reported by one ring
  typedef struct packed {
    logic full;
    logic empty;
    ptr_t wr_ptr;
    ptr_t rd_ptr;
  } ring_stat_t;

endpackage

### src/cdq_in_if.sv
interface cdq_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  ident_high;
  logic [7:0]  ident_low;
  logic [7:0]  ext_ident_high;
  logic [7:0]  ext_ident_low;
  logic [3:0]  frame_length;
  logic [31:0] payload_low;
  logic [31:0] payload_high;

  modport source (
    output valid, opcode, ident_high, ident_low, ext_ident_high, ext_ident_low,
           frame_length, payload_low, payload_high,
    input  ready
  );

  modport sink (
    input  valid, opcode, ident_high, ident_low, ext_ident_high, ext_ident_low,
           frame_length, payload_low, payload_high,
    output ready
  );
endinterface

### src/cdq_out_if.sv
interface cdq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  out_ident_high;
  logic [7:0]  out_ident_low;
  logic [7:0]  out_ext_ident_high;
  logic [7:0]  out_ext_ident_low;
  logic [3:0]  out_length;
  logic [31:0] out_payload_low;
  logic [31:0] out_payload_high;

  modport source (
    output valid, status, out_ident_high, out_ident_low, out_ext_ident_high,
           out_ext_ident_low, out_length, out_payload_low, out_payload_high,
    input  ready
  );

  modport sink (
    input  valid, status, out_ident_high, out_ident_low, out_ext_ident_high,
           out_ext_ident_low, out_length, out_payload_low, out_payload_high,
    output ready
  );
endinterface

### src/cdq_ram.sv
module cdq_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/cdq_ring.sv
module cdq_ring (
  input  logic               clk,
  input  logic               rst,
  input  cdq_pkg::ring_cmd_t cmd,
  output cdq_pkg::ring_stat_t stat
);

  cdq_pkg::ptr_t wr_ptr;
  cdq_pkg::ptr_t rd_ptr;
  cdq_pkg::ptr_t wr_ptr_inc;
  cdq_pkg::ptr_t rd_ptr_inc;

  // Wrap at the ring depth, which need not be a power of two
  always_comb begin
    wr_ptr_inc = (wr_ptr == cdq_pkg::ptr_t'(cdq_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr + cdq_pkg::ptr_t'(1);
    rd_ptr_inc = (rd_ptr == cdq_pkg::ptr_t'(cdq_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr + cdq_pkg::ptr_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (cmd.push) begin
        wr_ptr <= wr_ptr_inc;
      end
      if (cmd.pop) begin
        rd_ptr <= rd_ptr_inc;
      end
    end
  end

  // Full: one more write would catch the read pointer
  assign stat.full   = (wr_ptr_inc == rd_ptr);
  assign stat.empty  = (wr_ptr == rd_ptr);
  assign stat.wr_ptr = wr_ptr;
  assign stat.rd_ptr = rd_ptr;

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !stat.full)
    else $error("push into full ring");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !stat.empty)
    else $error("pop from empty ring");

  a_one_update: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.pop))
    else $error("push and pop in the same cycle");
`endif

endmodule

### src/can_rx_dual_queue_with_spill.sv
// Channel  Dir  Role                       Fields
// req      in   push frame / pop request   opcode, ident bytes, frame_length, payload
// rsp      out  one result per request     status, out_* frame fields
//
// Push: the ring pointers decide primary, spill or drop, and the
//   frame is written to that ring's RAM in the accept cycle.
// Pop: the selected ring's RAM has a registered read port, so the frame
//   is loaded from S_READ; an empty pop loads its status in the accept cycle.
// A finished result waits in an output register; the next request is taken
// in the cycle that register is emptied. Synchronous reset clears the pointers.
module can_rx_dual_queue_with_spill (
  input logic       clk,
  input logic       rst,
  cdq_in_if.sink    req,
  cdq_out_if.source rsp
);

  cdq_pkg::fsm_t       state;
  cdq_pkg::fsm_t       state_next;
  cdq_pkg::ring_cmd_t  pri_cmd;
  cdq_pkg::ring_cmd_t  spl_cmd;
  cdq_pkg::ring_stat_t pri_stat;
  cdq_pkg::ring_stat_t spl_stat;
  cdq_pkg::frame_t     push_frame;
  cdq_pkg::frame_t     pri_rdata;
  cdq_pkg::frame_t     spl_rdata;
  cdq_pkg::frame_t     rd_frame;
  cdq_pkg::frame_t     load_frame;
  cdq_pkg::status_t    load_status;
  cdq_pkg::frame_t     out_frame;
  cdq_pkg::status_t    out_status;
  logic                out_valid;
  logic                read_spill;
  logic                accept;
  logic                is_pop;
  logic                both_empty;
  logic                load_now;
  logic                load_read;
  logic [63:0]         rd_data;

  // Requests are taken only when idle and the output register can take a result
  assign req.ready  = (state == cdq_pkg::S_IDLE) && (!out_valid || rsp.ready);
  assign accept     = req.valid && req.ready;
  assign is_pop     = (cdq_pkg::opcode_t'(req.opcode) == cdq_pkg::OP_POP);
  assign both_empty = pri_stat.empty && spl_stat.empty;

  // Frame as stored, length saturated at eight
  always_comb begin
    push_frame.ident_high     = req.ident_high;
    push_frame.ident_low      = req.ident_low;
    push_frame.ext_ident_high = req.ext_ident_high;
    push_frame.ext_ident_low  = req.ext_ident_low;
    push_frame.length         = (req.frame_length > cdq_pkg::MAX_LEN) ?
                                cdq_pkg::MAX_LEN : req.frame_length;
    push_frame.payload_high   = req.payload_high;
    push_frame.payload_low    = req.payload_low;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      cdq_pkg::S_IDLE: begin
        if (accept && is_pop && !both_empty) begin
          state_next = cdq_pkg::S_READ;
        end
      end
      cdq_pkg::S_READ: begin
        state_next = cdq_pkg::S_IDLE;
      end
      default: begin
        state_next = cdq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // FSM outputs: ring updates, result loads
  always_comb begin
    pri_cmd     = '0;
    spl_cmd     = '0;
    load_now    = 1'b0;
    load_read   = 1'b0;
    case (state)
      cdq_pkg::S_IDLE: begin
        pri_cmd.push = accept && !is_pop && !pri_stat.full;
        spl_cmd.push = accept && !is_pop && pri_stat.full && !spl_stat.full;
        spl_cmd.pop  = accept && is_pop && !spl_stat.empty;
        pri_cmd.pop  = accept && is_pop && spl_stat.empty && !pri_stat.empty;
        load_now     = accept && (!is_pop || both_empty);
      end
      cdq_pkg::S_READ: begin
        load_read = 1'b1;
      end
      default: begin
        load_read = 1'b0;
      end
    endcase
  end

  // Remember which ring the pending read came from
  always_ff @(posedge clk) begin
    if (accept && is_pop) begin
      read_spill <= !spl_stat.empty;
    end
  end

  cdq_ring u_pri_ring (
    .clk  (clk),
    .rst  (rst),
    .cmd  (pri_cmd),
    .stat (pri_stat)
  );

  cdq_ring u_spl_ring (
    .clk  (clk),
    .rst  (rst),
    .cmd  (spl_cmd),
    .stat (spl_stat)
  );

  cdq_ram #(
    .DATA_W (cdq_pkg::FRAME_W),
    .DEPTH  (cdq_pkg::QUEUE_DEPTH)
  ) u_pri_ram (
    .clk   (clk),
    .we    (pri_cmd.push),
    .waddr (pri_stat.wr_ptr),
    .wdata (push_frame),
    .re    (pri_cmd.pop),
    .raddr (pri_stat.rd_ptr),
    .rdata (pri_rdata)
  );

  cdq_ram #(
    .DATA_W (cdq_pkg::FRAME_W),
    .DEPTH  (cdq_pkg::QUEUE_DEPTH)
  ) u_spl_ram (
    .clk   (clk),
    .we    (spl_cmd.push),
    .waddr (spl_stat.wr_ptr),
    .wdata (push_frame),
    .re    (spl_cmd.pop),
    .raddr (spl_stat.rd_ptr),
    .rdata (spl_rdata)
  );

  // Read frame, data bytes at or past the length cleared
  always_comb begin
    rd_frame = read_spill ? spl_rdata : pri_rdata;
    rd_data  = {rd_frame.payload_high, rd_frame.payload_low};
    for (int i = 0; i < 8; i++) begin
      if (4'(i) >= rd_frame.length) begin
        rd_data[i*8 +: 8] = 8'h00;
      end
    end
    rd_frame.payload_high = rd_data[63:32];
    rd_frame.payload_low  = rd_data[31:0];
  end

  // Result to load: popped frame, or a bare status
  always_comb begin
    load_frame  = '0;
    load_status = cdq_pkg::STAT_EMPTY;
    if (load_read) begin
      load_frame  = rd_frame;
      load_status = cdq_pkg::STAT_FRAME;
    end else if (!is_pop) begin
      if (!pri_stat.full) begin
        load_status = cdq_pkg::STAT_PRIMARY;
      end else if (!spl_stat.full) begin
        load_status = cdq_pkg::STAT_SPILL;
      end else begin
        load_status = cdq_pkg::STAT_DROPPED;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_now || load_read) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_now || load_read) begin
      out_frame  <= load_frame;
      out_status <= load_status;
    end
  end

  assign rsp.valid              = out_valid;
  assign rsp.status             = out_status;
  assign rsp.out_ident_high     = out_frame.ident_high;
  assign rsp.out_ident_low      = out_frame.ident_low;
  assign rsp.out_ext_ident_high = out_frame.ext_ident_high;
  assign rsp.out_ext_ident_low  = out_frame.ext_ident_low;
  assign rsp.out_length         = out_frame.length;
  assign rsp.out_payload_low    = out_frame.payload_low;
  assign rsp.out_payload_high   = out_frame.payload_high;

`ifndef SYNTHESIS
  a_read_loads: assert property (@(posedge clk) disable iff (rst)
    (state == cdq_pkg::S_READ) |=> (out_valid && out_status == cdq_pkg::STAT_FRAME))
    else $error("pending read did not produce a frame result");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (accept && is_pop && both_empty) |=>
      (out_valid && out_status == cdq_pkg::STAT_EMPTY))
    else $error("pop of empty store did not report empty");

  a_push_status: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_pop) |=>
      (out_valid && (out_status == cdq_pkg::STAT_PRIMARY ||
                     out_status == cdq_pkg::STAT_SPILL ||
                     out_status == cdq_pkg::STAT_DROPPED)))
    else $error("push did not report a push status");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |-> !(load_now || load_read))
    else $error("result overwritten before transfer");
`endif

endmodule
